// ===== src/tdhp_pkg.sv =====
// Shared types, constants and helper functions of the drop height profile block.
`timescale 1ns / 1ps

package tdhp_pkg;

   localparam int BOARD_W   = 4;
   localparam int TYPE_W    = 3;
   localparam int ANCHOR_W  = 7;
   localparam int TURNS_W   = 2;
   localparam int WIDTH_W   = 8;
   localparam int HEIGHT_W  = 20;
   localparam int LANDING_W = 21;
   localparam int CALC_W    = 23;
   localparam int OFFSET_W  = 3;
   localparam int CELLS     = 4;
   localparam int NUM_SHAPES = 7;
   localparam int BOARD_CODES = 2 ** BOARD_W;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET = 8'd100;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX  = {HEIGHT_W{1'b1}};
   localparam logic [TYPE_W-1:0]   PIECE_NONE  = 3'd7;

   typedef struct packed {
      logic [BOARD_W-1:0]  board;
      logic [TYPE_W-1:0]   piece_type;
      logic [ANCHOR_W-1:0] anchor_column;
      logic [TURNS_W-1:0]  quarter_turns;
   } req_payload_type;

   typedef struct packed {
      logic signed [LANDING_W-1:0] landing_row;
      logic                        height_saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [OFFSET_W-1:0] dx;
      logic signed [OFFSET_W-1:0] dy;
   } offset_type;

   // Status of the anchor remainder unit: done pulses for one cycle with the result.
   typedef struct packed {
      logic               done;
      logic [WIDTH_W-1:0] remainder;
   } mod_status_type;

   localparam logic signed [OFFSET_W-1:0] SHAPE_DX [NUM_SHAPES][CELLS] = '{
      '{3'sd0, 3'sd0, 3'sd0, 3'sd0},
      '{3'sd0, 3'sd1, 3'sd2, 3'sd2},
      '{3'sd0, 3'sd1, 3'sd2, 3'sd2},
      '{3'sd0, 3'sd1, 3'sd1, 3'sd2},
      '{3'sd0, 3'sd1, 3'sd1, 3'sd0},
      '{3'sd0, 3'sd1, 3'sd1, 3'sd2},
      '{3'sd0, 3'sd1, 3'sd1, 3'sd2}
   };

   localparam logic signed [OFFSET_W-1:0] SHAPE_DY [NUM_SHAPES][CELLS] = '{
      '{3'sd0, 3'sd1, 3'sd2, 3'sd3},
      '{3'sd0, 3'sd0, 3'sd0, 3'sd1},
      '{3'sd0, 3'sd0, 3'sd0, -3'sd1},
      '{3'sd0, 3'sd0, 3'sd1, 3'sd0},
      '{3'sd0, 3'sd0, 3'sd1, 3'sd1},
      '{3'sd0, 3'sd0, 3'sd1, 3'sd1},
      '{3'sd0, 3'sd0, -3'sd1, -3'sd1}
   };

   // Base cell offset of a shape, turned k quarter turns by (dx,dy) -> (-dy,dx).
   function automatic offset_type cell_offset(input logic [TYPE_W-1:0] t,
                                              input logic [1:0] i,
                                              input logic [TURNS_W-1:0] k);
      offset_type c;
      offset_type r;
      c.dx = SHAPE_DX[t][i];
      c.dy = SHAPE_DY[t][i];
      case (k)
         2'd0: r = c;
         2'd1: begin
            r.dx = -c.dy;
            r.dy = c.dx;
         end
         2'd2: begin
            r.dx = -c.dx;
            r.dy = -c.dy;
         end
         2'd3: begin
            r.dx = c.dy;
            r.dy = -c.dx;
         end
         default: r = c;
      endcase
      return r;
   endfunction

   // Brings remainder plus offset back into [0, w); three steps cover widths down to one.
   function automatic logic [WIDTH_W-1:0] wrap_column(input logic signed [WIDTH_W+1:0] s,
                                                     input logic [WIDTH_W-1:0] w);
      logic signed [WIDTH_W+1:0] v;
      logic signed [WIDTH_W+1:0] ws;
      v  = s;
      ws = $signed({2'b00, w});
      for (int n = 0; n < 3; n++) begin
         if (v < 0) begin
            v = v + ws;
         end else if (v >= ws) begin
            v = v - ws;
         end
      end
      return v[WIDTH_W-1:0];
   endfunction

   function automatic logic signed [CALC_W-1:0] sext_offset(
         input logic signed [OFFSET_W-1:0] d);
      return {{(CALC_W-OFFSET_W){d[OFFSET_W-1]}}, d};
   endfunction

endpackage

// ===== src/tetromino_drop_height_profile.sv =====
// Top level: drops four-cell pieces onto column height profiles kept in one memory.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  board, piece_type, anchor_column, quarter_turns
// rsp_      out        rsp_valid/rsp_ready  landing_row, height_saturated
// csr_      in         csr_we               csr_wdata = active_width
//
// A drop reads the height memory four times and writes it four times; an anchor column
// at or past the active width first goes through the bit-serial remainder unit.
// After reset the memory is cleared one entry a cycle, all BOARDS * MAX_COLUMNS entries
// (2048 at the defaults), and req_ready stays low until that pass ends.
// A stalled result sits in the output register; the next transaction is accepted and
// worked on meanwhile and only waits at its very end for the output register to empty.

module tetromino_drop_height_profile #(
   parameter int MAX_COLUMNS = 128,
   parameter int BOARDS      = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tdhp_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tdhp_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_we,
   input  logic [tdhp_pkg::WIDTH_W-1:0]      csr_wdata
);

   localparam int DEPTH = BOARDS * MAX_COLUMNS;
   localparam int AW    = $clog2(DEPTH);

   // Base address of each board code, with the code wrapped modulo BOARDS.
   function automatic logic [tdhp_pkg::BOARD_CODES-1:0][AW-1:0] board_base_table();
      logic [tdhp_pkg::BOARD_CODES-1:0][AW-1:0] tbl;
      int r;
      r = 0;
      for (int i = 0; i < tdhp_pkg::BOARD_CODES; i++) begin
         tbl[i] = AW'(r * MAX_COLUMNS);
         r = (r == BOARDS - 1) ? 0 : r + 1;
      end
      return tbl;
   endfunction

   localparam logic [tdhp_pkg::BOARD_CODES-1:0][AW-1:0] BOARD_BASE = board_base_table();

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_COLS,
      ST_READ,
      ST_WRITE,
      ST_DONE
   } state_type;

   state_type                              state_ff;
   logic [AW-1:0]                          clr_ff;
   logic [tdhp_pkg::WIDTH_W-1:0]           active_width_ff;
   logic [tdhp_pkg::TURNS_W-1:0]           orient_ff [tdhp_pkg::NUM_SHAPES];

   // Per-transaction working registers.
   logic [AW-1:0]                          base_ff;
   logic [tdhp_pkg::TYPE_W-1:0]            type_ff;
   logic [tdhp_pkg::TURNS_W-1:0]           orient_sel_ff;
   logic [tdhp_pkg::WIDTH_W-1:0]           rem_ff;
   logic [AW-1:0]                          addr_ff [tdhp_pkg::CELLS];
   logic signed [tdhp_pkg::OFFSET_W-1:0]   dy_ff [tdhp_pkg::CELLS];
   logic [tdhp_pkg::HEIGHT_W-1:0]          h_ff [tdhp_pkg::CELLS];
   logic [2:0]                             step_ff;
   logic signed [tdhp_pkg::CALC_W-1:0]     landing_ff;
   logic                                   sat_ff;

   logic                                   rsp_valid_ff;
   tdhp_pkg::rsp_payload_type              rsp_payload_ff;

   // Height memory: one write and one registered read a cycle.
   logic [tdhp_pkg::HEIGHT_W-1:0]          height_mem [DEPTH];
   logic [tdhp_pkg::HEIGHT_W-1:0]          mem_rdata_ff;
   logic                                   mem_we;
   logic [AW-1:0]                          mem_waddr;
   logic [tdhp_pkg::HEIGHT_W-1:0]          mem_wdata;
   logic [AW-1:0]                          mem_raddr;

   logic [tdhp_pkg::WIDTH_W-1:0]           width_eff;
   logic                                   accept;
   logic                                   need_mod;
   logic [tdhp_pkg::TURNS_W-1:0]           orient_cur;
   tdhp_pkg::mod_status_type               mod_status;

   logic [1:0]                             rd_idx;
   logic signed [tdhp_pkg::CALC_W-1:0]     cand;
   logic [1:0]                             wr_idx;
   logic [tdhp_pkg::HEIGHT_W-1:0]          wr_value;
   logic                                   wr_clip;
   logic signed [tdhp_pkg::CALC_W-1:0]     landing_clip;

   // Width zero acts as one column; widths past the storage act as the full row.
   always_comb begin
      if (active_width_ff == '0) begin
         width_eff = tdhp_pkg::WIDTH_W'(1);
      end else if (int'(active_width_ff) > MAX_COLUMNS) begin
         width_eff = tdhp_pkg::WIDTH_W'(MAX_COLUMNS);
      end else begin
         width_eff = active_width_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign need_mod  = ({1'b0, req_payload.anchor_column} >= width_eff) &&
                      (req_payload.piece_type != tdhp_pkg::PIECE_NONE);

   always_comb begin
      if (req_payload.piece_type == tdhp_pkg::PIECE_NONE) begin
         orient_cur = '0;
      end else begin
         orient_cur = orient_ff[req_payload.piece_type] + req_payload.quarter_turns;
      end
   end

   tdhp_anchor_mod u_anchor_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && need_mod),
      .dividend (req_payload.anchor_column),
      .divisor  (width_eff),
      .status   (mod_status)
   );

   // Read side: cell k is addressed at step k, and its height comes back through the registered read data.
   assign rd_idx    = step_ff[1:0] - 2'd1;
   assign mem_raddr = addr_ff[step_ff[1:0]];
   assign cand      = $signed({3'b000, mem_rdata_ff}) + tdhp_pkg::CALC_W'(1)
                      - tdhp_pkg::sext_offset(dy_ff[rd_idx]);

   // Write side. Cells that share a column all write the largest value that any of them
   // would leave there, so a later write never undoes an earlier one.
   assign wr_idx = step_ff[1:0];

   always_comb begin
      logic signed [tdhp_pkg::CALC_W-1:0] nh;
      logic [tdhp_pkg::HEIGHT_W-1:0]      nh_clip;
      wr_value = h_ff[wr_idx];
      wr_clip  = 1'b0;
      for (int j = 0; j < tdhp_pkg::CELLS; j++) begin
         nh = landing_ff + tdhp_pkg::sext_offset(dy_ff[j]);
         if (nh > $signed({3'b000, tdhp_pkg::HEIGHT_MAX})) begin
            nh_clip = tdhp_pkg::HEIGHT_MAX;
            if (j == int'(wr_idx)) begin
               wr_clip = 1'b1;
            end
         end else begin
            nh_clip = nh[tdhp_pkg::HEIGHT_W-1:0];
         end
         if ((addr_ff[j] == addr_ff[wr_idx]) && (nh_clip > wr_value)) begin
            wr_value = nh_clip;
         end
      end
   end

   always_comb begin
      if (landing_ff > $signed({3'b000, tdhp_pkg::HEIGHT_MAX})) begin
         landing_clip = $signed({3'b000, tdhp_pkg::HEIGHT_MAX});
      end else begin
         landing_clip = landing_ff;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff[wr_idx];
      mem_wdata = wr_value;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (state_ff == ST_WRITE) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         height_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= height_mem[mem_raddr];
   end

   // The user must write the register only while the block is idle; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_width_ff <= tdhp_pkg::WIDTH_RESET;
      end else if (csr_we) begin
         active_width_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < tdhp_pkg::NUM_SHAPES; t++) begin
            orient_ff[t] <= '0;
         end
      end else begin
         // In the done state the output register is reloaded instead.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end

            ST_IDLE: begin
               if (accept) begin
                  base_ff       <= BOARD_BASE[req_payload.board];
                  type_ff       <= req_payload.piece_type;
                  orient_sel_ff <= orient_cur;
                  rem_ff        <= {1'b0, req_payload.anchor_column};
                  sat_ff        <= 1'b0;
                  landing_ff    <= '0;
                  if (req_payload.piece_type == tdhp_pkg::PIECE_NONE) begin
                     // An unused type code changes nothing and reports a zero result.
                     state_ff <= ST_DONE;
                  end else begin
                     orient_ff[req_payload.piece_type] <= orient_cur;
                     state_ff <= need_mod ? ST_DIV : ST_COLS;
                  end
               end
            end

            ST_DIV: begin
               if (mod_status.done) begin
                  rem_ff   <= mod_status.remainder;
                  state_ff <= ST_COLS;
               end
            end

            ST_COLS: begin
               for (int i = 0; i < tdhp_pkg::CELLS; i++) begin
                  tdhp_pkg::offset_type off;
                  logic [tdhp_pkg::WIDTH_W-1:0] col;
                  off = tdhp_pkg::cell_offset(type_ff, 2'(i), orient_sel_ff);
                  col = tdhp_pkg::wrap_column(
                           $signed({2'b00, rem_ff}) +
                           {{(tdhp_pkg::WIDTH_W-1){off.dx[tdhp_pkg::OFFSET_W-1]}}, off.dx},
                           width_eff);
                  addr_ff[i] <= base_ff + AW'(col);
                  dy_ff[i]   <= off.dy;
               end
               step_ff  <= '0;
               state_ff <= ST_READ;
            end

            ST_READ: begin
               if (step_ff != 3'd0) begin
                  h_ff[rd_idx] <= mem_rdata_ff;
                  if ((step_ff == 3'd1) || (cand > landing_ff)) begin
                     landing_ff <= cand;
                  end
               end
               if (step_ff == 3'd4) begin
                  step_ff  <= '0;
                  state_ff <= ST_WRITE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end

            ST_WRITE: begin
               step_ff <= step_ff + 1'b1;
               if (wr_clip) begin
                  sat_ff <= 1'b1;
               end
               if (step_ff == 3'd3) begin
                  state_ff <= ST_DONE;
               end
            end

            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff                   <= 1'b1;
                  rsp_payload_ff.landing_row      <= landing_clip[tdhp_pkg::LANDING_W-1:0];
                  rsp_payload_ff.height_saturated <= sat_ff;
                  state_ff                       <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== src/tdhp_anchor_mod.sv =====
// Restoring remainder unit: anchor column modulo the active width, one bit a cycle.
`timescale 1ns / 1ps

module tdhp_anchor_mod (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [tdhp_pkg::ANCHOR_W-1:0]     dividend,
   input  logic [tdhp_pkg::WIDTH_W-1:0]      divisor,
   output tdhp_pkg::mod_status_type          status
);

   localparam int CNT_W = $clog2(tdhp_pkg::ANCHOR_W);

   logic                            busy_ff;
   logic                            done_ff;
   logic [CNT_W-1:0]                cnt_ff;
   logic [tdhp_pkg::ANCHOR_W-1:0]   bits_ff;
   logic [tdhp_pkg::WIDTH_W-1:0]    div_ff;
   logic [tdhp_pkg::WIDTH_W-1:0]    rem_ff;
   logic [tdhp_pkg::WIDTH_W-1:0]    rem_in;
   logic [tdhp_pkg::WIDTH_W:0]      trial;

   always_comb begin
      trial = {rem_ff, bits_ff[tdhp_pkg::ANCHOR_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = tdhp_pkg::WIDTH_W'(trial - {1'b0, div_ff});
      end else begin
         rem_in = trial[tdhp_pkg::WIDTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNT_W'(tdhp_pkg::ANCHOR_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            bits_ff <= dividend;
            div_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            bits_ff <= {bits_ff[tdhp_pkg::ANCHOR_W-2:0], 1'b0};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(tdhp_pkg::ANCHOR_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

// ===== verif/tdhp_drop_checker.sv =====
// Checker that predicts the landing row of each drop and compares it with the block's results.
`timescale 1ns / 1ps

module tdhp_drop_checker #(
   parameter int MAX_COLUMNS = 128,
   parameter int BOARDS      = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  tdhp_pkg::req_payload_type req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  tdhp_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_we,
   input  logic [7:0]                csr_wdata,
   output int                        failures,
   output int                        outstanding
);

   localparam int HEIGHT_LIMIT = (1 << 20) - 1;

   // Base cell offsets of the seven shapes, in the order I L J T O Z S.
   localparam int BASE_DX [7][4] = '{
      '{0, 0, 0, 0}, '{0, 1, 2, 2}, '{0, 1, 2, 2}, '{0, 1, 1, 2},
      '{0, 1, 1, 0}, '{0, 1, 1, 2}, '{0, 1, 1, 2}
   };
   localparam int BASE_DY [7][4] = '{
      '{0, 1, 2, 3}, '{0, 0, 0, 1}, '{0, 0, 0, -1}, '{0, 0, 1, 0},
      '{0, 0, 1, 1}, '{0, 0, 1, 1}, '{0, 0, -1, -1}
   };

   logic [19:0]               profile [BOARDS][MAX_COLUMNS];
   logic [1:0]                kept_turns [7];
   logic [7:0]                width_reg;
   tdhp_pkg::rsp_payload_type landing_queue [$];
   int                        mismatches;

   function automatic tdhp_pkg::rsp_payload_type drop_piece(
         input tdhp_pkg::req_payload_type p);
      tdhp_pkg::rsp_payload_type r;
      int              w;
      int              dx;
      int              dy;
      int              tmp;
      int              landing;
      int              cand;
      int              nh;
      int              cols [4];
      int              dys [4];
      logic            sat;
      logic [1:0]      orient;
      int              b;
      int              t;
      r   = '0;
      sat = 1'b0;
      if (p.piece_type == tdhp_pkg::PIECE_NONE) begin
         return r;
      end
      b = int'(p.board) % BOARDS;
      t = int'(p.piece_type);
      w = int'(width_reg);
      if (w == 0) begin
         w = 1;
      end
      if (w > MAX_COLUMNS) begin
         w = MAX_COLUMNS;
      end
      orient = kept_turns[t] + p.quarter_turns;
      kept_turns[t] = orient;
      landing = 0;
      for (int i = 0; i < 4; i++) begin
         dx = BASE_DX[t][i];
         dy = BASE_DY[t][i];
         for (int k = 0; k < int'(orient); k++) begin
            tmp = dx;
            dx  = -dy;
            dy  = tmp;
         end
         cols[i] = (int'(p.anchor_column) + dx + 4 * w) % w;
         dys[i]  = dy;
         cand    = int'(profile[b][cols[i]]) + 1 - dy;
         if (i == 0 || cand > landing) begin
            landing = cand;
         end
      end
      // Cells that share a column leave the largest of their heights behind.
      for (int i = 0; i < 4; i++) begin
         nh = landing + dys[i];
         if (nh > HEIGHT_LIMIT) begin
            nh  = HEIGHT_LIMIT;
            sat = 1'b1;
         end
         if (nh > int'(profile[b][cols[i]])) begin
            profile[b][cols[i]] = nh[19:0];
         end
      end
      if (landing > HEIGHT_LIMIT) begin
         landing = HEIGHT_LIMIT;
      end
      r.landing_row      = landing[20:0];
      r.height_saturated = sat;
      return r;
   endfunction

   always @(posedge clock) begin
      tdhp_pkg::rsp_payload_type want;
      if (reset) begin
         for (int b = 0; b < BOARDS; b++) begin
            for (int c = 0; c < MAX_COLUMNS; c++) begin
               profile[b][c] = '0;
            end
         end
         for (int t = 0; t < 7; t++) begin
            kept_turns[t] = '0;
         end
         width_reg = 8'd100;
         landing_queue.delete();
         mismatches = 0;
         failures    <= 0;
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            width_reg = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (landing_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result: landing %0d sat %0b",
                           $signed(rsp_payload.landing_row), rsp_payload.height_saturated);
               end
            end else begin
               want = landing_queue.pop_front();
               if (rsp_payload.landing_row !== want.landing_row ||
                   rsp_payload.height_saturated !== want.height_saturated) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected landing %0d sat %0b, got landing %0d sat %0b",
                              $signed(want.landing_row), want.height_saturated,
                              $signed(rsp_payload.landing_row), rsp_payload.height_saturated);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            landing_queue.push_back(drop_piece(req_payload));
         end
         failures    <= mismatches;
         outstanding <= landing_queue.size();
      end
   end

endmodule

// ===== verif/tb_tetromino_drop_height_profile.sv =====
// Testbench top: drives drops and width settings into the block and reports the verdict.
`timescale 1ns / 1ps

module tb_tetromino_drop_height_profile;

   // Piece shape codes as the block numbers them.
   typedef enum logic [2:0] {
      PIECE_I, PIECE_L, PIECE_J, PIECE_T, PIECE_O, PIECE_Z, PIECE_S, PIECE_SKIP
   } piece_code_type;

   // Cycles without any accepted transaction before the run is declared hung. The limit covers
   // the clearing pass after reset as well as any single drop.
   localparam int WATCHDOG_LIMIT = 20000;
   // Quiet cycles allowed after the last result before a width write or the verdict.
   localparam int SETTLE_CYCLES  = 24;
   localparam int PHASE_ITEMS    = 160;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   tdhp_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   tdhp_pkg::rsp_payload_type rsp_payload;
   logic                      csr_we      = 1'b0;
   logic [7:0]                csr_wdata   = 8'd0;

   int   failures;
   int   outstanding;
   int   idle_cycles = 0;
   // When set, neither side inserts idle cycles.
   logic steady      = 1'b0;
   // Width as the block applies it, used to keep most anchors below the width.
   int   width_in_use = 100;

   tetromino_drop_height_profile DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   tdhp_drop_checker CHECKER (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The result side stalls at random in roughly 37 percent of the cycles, except while the
   // steady flag is set.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 37);
   end

   // Any accepted transaction on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Presents one drop, optionally after random idle cycles, and returns at the clock edge
   // where the transaction is accepted. Valid is only lowered in a gap, so it is never
   // dropped and raised within one time step.
   task automatic push_drop(input tdhp_pkg::req_payload_type p);
      if (!steady) begin
         while ($urandom_range(0, 99) < 37) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // Stops the sender and waits until every predicted result has been returned, then waits
   // out the settle time so the block has finished its last drop.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the width register while the block is idle.
   task automatic set_width(input logic [7:0] w);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we <= 1'b0;
      if (w == 8'd0) begin
         width_in_use = 1;
      end else if (w > 8'd128) begin
         width_in_use = 128;
      end else begin
         width_in_use = int'(w);
      end
   endtask

   function automatic tdhp_pkg::req_payload_type make_drop(input int b,
                                                           input piece_code_type t,
                                                           input int anchor,
                                                           input int turns);
      tdhp_pkg::req_payload_type p;
      p.board         = b[3:0];
      p.piece_type    = t;
      p.anchor_column = anchor[6:0];
      p.quarter_turns = turns[1:0];
      return p;
   endfunction

   // A random drop: mostly real pieces with anchors inside the width, sometimes a skipped
   // piece code or an anchor anywhere in its range so that it can wrap.
   function automatic tdhp_pkg::req_payload_type random_drop(input int board_span);
      piece_code_type t;
      int             anchor;
      if ($urandom_range(0, 15) == 0) begin
         t = PIECE_SKIP;
      end else begin
         t = piece_code_type'($urandom_range(0, 6));
      end
      if ($urandom_range(0, 9) == 0) begin
         anchor = $urandom_range(0, 127);
      end else begin
         anchor = $urandom_range(0, width_in_use - 1);
      end
      return make_drop($urandom_range(0, board_span), t, anchor, $urandom_range(0, 3));
   endfunction

   initial begin
      int widths [10];
      int board_span;
      widths = '{1, 128, 0, 255, 4, 200, 37, 100, 2, 65};
      widths[6] = $urandom_range(5, 120);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part on a narrow board so that wrapping shows up quickly.
      set_width(8'd10);
      // Every shape on a fresh board, each turn count in use.
      for (int t = 0; t < 7; t++) begin
         push_drop(make_drop(0, piece_code_type'(t), 0, t % 4));
      end
      // Every shape on the last board with the highest anchor, which lies past the width.
      for (int t = 0; t < 7; t++) begin
         push_drop(make_drop(15, piece_code_type'(t), 127, 3));
      end
      // The unused piece code must leave all state alone and return a zero result.
      push_drop(make_drop(0, PIECE_SKIP, 5, 1));
      // Drops near the last column and near column zero.
      push_drop(make_drop(0, PIECE_L, 9, 2));
      push_drop(make_drop(0, PIECE_I, 1, 1));
      // The same square twice in the same place stacks on itself.
      push_drop(make_drop(3, PIECE_O, 4, 0));
      push_drop(make_drop(3, PIECE_O, 4, 0));

      // Random part. Every width change first waits for all results, which also covers the
      // sender pausing until nothing is outstanding. The widths include one, the largest,
      // zero and values above the column count. Odd phases use all boards; even phases
      // pile onto two boards so that the profiles grow tall.
      for (int ph = 0; ph < 10; ph++) begin
         set_width(widths[ph][7:0]);
         steady     = (ph == 5);
         board_span = (ph % 2 == 1) ? 15 : 1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            push_drop(random_drop(board_span));
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== tetromino_drop_height_profile.f =====
src/tdhp_pkg.sv
src/tdhp_anchor_mod.sv
src/tetromino_drop_height_profile.sv
verif/tdhp_drop_checker.sv
verif/tb_tetromino_drop_height_profile.sv
